// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  `ASSERT_PROP(lbl, clk, rstn, (ante) |-> (cons))

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `ASSERT_PROP(lbl, clk, rstn, (ante) |=> (cons))

`endif

// ===== rtl/core/rfhr_pkg.sv =====
package rfhr_pkg;

  // Default sizes
  localparam int RING_DEPTH_DEF = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int SLOTS_W = 5;
  localparam int COUNT_W = 5;

  // Slot count after reset
  localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

endpackage

// ===== rtl/core/rfhr_req_if.sv =====
interface rfhr_req_if #(
  parameter int WORD_WIDTH = rfhr_pkg::WORD_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [WORD_WIDTH-1:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

// ===== rtl/core/rfhr_rsp_if.sv =====
interface rfhr_rsp_if #(
  parameter int WORD_WIDTH = rfhr_pkg::WORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [WORD_WIDTH-1:0]         data_out;
  logic [rfhr_pkg::COUNT_W-1:0]  element_count;

  modport source (output valid, output accepted, output data_out, output element_count,
                  input ready);
  modport sink   (input valid, input accepted, input data_out, input element_count,
                  output ready);
endinterface

// ===== rtl/core/rfhr_cfg_if.sv =====
interface rfhr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rfhr_pkg::SLOTS_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rfhr_ram.sv =====
module rfhr_ram #(
  parameter int WIDTH = rfhr_pkg::WORD_WIDTH_DEF,
  parameter int DEPTH = rfhr_pkg::RING_DEPTH_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/ring_fifo_with_head_register.sv =====
// Ring FIFO with a front holding register; one result item per accepted item.
// The result is registered and shows in the cycle after the item is accepted.
// Throughput: one item per cycle while no result waits unread; a dequeue that
// refills the front word from the ring RAM holds input in the REFILL state.
// Reset: asynchronous, active low; pointers, count and front flag clear, slots = 16.
`include "assert_macros.svh"

module ring_fifo_with_head_register #(
  parameter int RING_DEPTH = rfhr_pkg::RING_DEPTH_DEF,
  parameter int WORD_WIDTH = rfhr_pkg::WORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfhr_req_if.sink    req_i,
  rfhr_rsp_if.source  rsp_o,
  rfhr_cfg_if.sink    cfg_i
);
  import rfhr_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CMP_W = (PTR_W + 1 > SLOTS_W) ? PTR_W + 1 : SLOTS_W;

  // Sequencer codes
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REFILL = 1'b1;

  logic                  state_q, state_d;
  logic [SLOTS_W-1:0]    slots_q;
  logic [CMP_W-1:0]      slots_eff;
  logic [PTR_W-1:0]      rp_q, rp_d, wp_q, wp_d, wp_next;
  logic                  front_valid_q, front_valid_d;
  logic [WORD_WIDTH-1:0] front_q, front_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic                  rsp_valid_q, rsp_valid_d;
  logic                  rsp_acc_q, rsp_acc_d;
  logic [WORD_WIDTH-1:0] rsp_data_q, rsp_data_d;
  logic [COUNT_W-1:0]    rsp_count_q, rsp_count_d;
  logic                  in_ready, in_acc, ring_empty, ring_full;
  logic                  ram_we;
  logic [WORD_WIDTH-1:0] ram_rdata;

  // Pointer step with compare wrap
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CMP_W-1:0] s);
    logic [CMP_W-1:0] n;
    n = CMP_W'(p) + CMP_W'(1);
    return (n >= s) ? '0 : n[PTR_W-1:0];
  endfunction

  // Clamp slot count into 2 .. RING_DEPTH
  always_comb begin
    if (CMP_W'(slots_q) < CMP_W'(2)) begin
      slots_eff = CMP_W'(2);
    end else if (CMP_W'(slots_q) > CMP_W'(RING_DEPTH)) begin
      slots_eff = CMP_W'(RING_DEPTH);
    end else begin
      slots_eff = CMP_W'(slots_q);
    end
  end

  // Handshakes
  assign in_ready      = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign in_acc        = req_i.valid && in_ready;
  assign req_i.ready   = in_ready;
  assign cfg_i.ready   = 1'b1;

  assign ring_empty = (rp_q == wp_q);
  assign wp_next    = advance(wp_q, slots_eff);
  assign ring_full  = (rp_q == wp_next);

  // Operation decode and state update
  always_comb begin
    state_d       = state_q;
    rp_d          = rp_q;
    wp_d          = wp_q;
    front_valid_d = front_valid_q;
    front_d       = front_q;
    count_d       = count_q;
    rsp_valid_d   = rsp_valid_q;
    rsp_acc_d     = rsp_acc_q;
    rsp_data_d    = rsp_data_q;
    rsp_count_d   = rsp_count_q;
    ram_we        = 1'b0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    // Front word arrives from the ring in the REFILL state, the cycle after the read
    if (state_q == ST_REFILL) begin
      front_d = ram_rdata;
      state_d = ST_IDLE;
    end

    if (in_acc) begin
      rsp_valid_d = 1'b1;
      rsp_acc_d   = 1'b0;
      rsp_data_d  = '0;
      case (req_i.operation)
        OP_ENQ: begin
          if (!ring_full) begin
            rsp_acc_d = 1'b1;
            count_d   = count_q + COUNT_W'(1);
            if (ring_empty && !front_valid_q) begin
              front_d       = req_i.data_in;
              front_valid_d = 1'b1;
            end else begin
              ram_we = 1'b1;
              wp_d   = wp_next;
            end
          end
        end
        OP_DEQ: begin
          if (front_valid_q) begin
            rsp_acc_d  = 1'b1;
            rsp_data_d = front_q;
            count_d    = count_q - COUNT_W'(1);
            if (ring_empty) begin
              front_valid_d = 1'b0;
            end else begin
              rp_d    = advance(rp_q, slots_eff);
              state_d = ST_REFILL;
            end
          end
        end
        default: begin
          rsp_acc_d = 1'b0;
        end
      endcase
      rsp_count_d = count_d;
    end
  end

  // Ring store: write at tail, read at head
  rfhr_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (req_i.data_in),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      slots_q       <= SLOTS_RESET;
      rp_q          <= '0;
      wp_q          <= '0;
      front_valid_q <= 1'b0;
      count_q       <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rp_q          <= rp_d;
      wp_q          <= wp_d;
      front_valid_q <= front_valid_d;
      count_q       <= count_d;
      rsp_valid_q   <= rsp_valid_d;
      if (cfg_i.valid) begin
        slots_q <= cfg_i.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    front_q     <= front_d;
    rsp_acc_q   <= rsp_acc_d;
    rsp_data_q  <= rsp_data_d;
    rsp_count_q <= rsp_count_d;
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.accepted      = rsp_acc_q;
  assign rsp_o.data_out      = rsp_data_q;
  assign rsp_o.element_count = rsp_count_q;

  // Checks
  `ASSERT_IMPLY(a_refill_has_front, clk_i, rst_ni, state_q == ST_REFILL, front_valid_q)
  `ASSERT_IMPLY(a_free_front_empty_ring, clk_i, rst_ni, !front_valid_q, rp_q == wp_q)
  `ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_acc, rsp_valid_q)

endmodule
